// ===== src/amg_pkg.sv =====
// Shared types, codes and constants of the adjacency matrix graph store.
`timescale 1ns / 1ps
`default_nettype none
package amg_pkg;

  // Default size of the vertex set
  localparam int unsigned MAX_VERTICES_DEF = 16;

  // Fixed field widths of the request and result words
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VTX_W    = 8;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned COUNT_W  = 5;

  // Entries of the command queue between front and back
  localparam int unsigned CMD_QUEUE_DEPTH = 2;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD_VERTEX    = 3'd0,
    OP_ADD_EDGE      = 3'd1,
    OP_REMOVE_EDGE   = 3'd2,
    OP_REMOVE_VERTEX = 3'd3,
    OP_READ_EDGE     = 3'd4
  } op_e;

  // Matrix work that the back end carries out for one word
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_e;

  // Classified word handed from front to back
  typedef struct packed {
    cmd_kind_e           kind;
    logic                mirror;
    logic [VTX_W-1:0]    from_vertex;
    logic [VTX_W-1:0]    to_vertex;
    logic [WEIGHT_W-1:0] weight;
    logic                status;
    logic [COUNT_W-1:0]  vertex_count;
    logic                graph_empty;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/amg_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module amg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/amg_front.sv =====
// Front end: accepts request words, checks vertices, keeps presence and count.
`timescale 1ns / 1ps
`default_nettype none
module amg_front #(
  parameter int unsigned MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [amg_pkg::OP_W-1:0]         operation_i,
  input  wire logic [amg_pkg::VTX_W-1:0]        from_vertex_i,
  input  wire logic [amg_pkg::VTX_W-1:0]        to_vertex_i,
  input  wire logic [amg_pkg::WEIGHT_W-1:0]     edge_weight_in_i,
  input  wire logic                             queue_full_i,
  output logic                                  push_o,
  output amg_pkg::cmd_t                         cmd_o
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [amg_pkg::VTX_W:0] VTX_LIMIT = (amg_pkg::VTX_W + 1)'(MAX_VERTICES);

  logic                    directed_q;
  logic [MAX_VERTICES-1:0] present_q, present_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    from_in_range, to_in_range;
  logic                    from_ok, to_ok;
  logic                    accept;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;
  assign push_o     = accept;

  // Range and presence checks
  assign from_in_range = {1'b0, from_vertex_i} < VTX_LIMIT;
  assign to_in_range   = {1'b0, to_vertex_i} < VTX_LIMIT;
  assign from_ok = from_in_range && present_q[from_vertex_i[VW-1:0]];
  assign to_ok   = to_in_range && present_q[to_vertex_i[VW-1:0]];

  // Classify the word and work out presence and count after it
  always_comb begin
    present_d           = present_q;
    count_d             = count_q;
    cmd_o.kind          = amg_pkg::CMD_NONE;
    cmd_o.mirror        = !directed_q;
    cmd_o.from_vertex   = from_vertex_i;
    cmd_o.to_vertex     = to_vertex_i;
    cmd_o.weight        = '0;
    cmd_o.status        = 1'b1;
    case (operation_i)
      amg_pkg::OP_ADD_VERTEX: begin
        if (from_in_range && !present_q[from_vertex_i[VW-1:0]]) begin
          // A new vertex gets its row and column wiped before use
          present_d[from_vertex_i[VW-1:0]] = 1'b1;
          count_d      = count_q + CNT_W'(1);
          cmd_o.kind   = amg_pkg::CMD_CLEAR;
          cmd_o.status = 1'b0;
        end
      end
      amg_pkg::OP_ADD_EDGE: begin
        if (from_ok && to_ok) begin
          cmd_o.kind   = amg_pkg::CMD_WRITE;
          cmd_o.weight = edge_weight_in_i;
          cmd_o.status = 1'b0;
        end
      end
      amg_pkg::OP_REMOVE_EDGE: begin
        if (from_ok && to_ok) begin
          cmd_o.kind   = amg_pkg::CMD_WRITE;
          cmd_o.status = 1'b0;
        end
      end
      amg_pkg::OP_REMOVE_VERTEX: begin
        if (from_ok) begin
          present_d[from_vertex_i[VW-1:0]] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CNT_W'(1);
          end
          cmd_o.status = 1'b0;
        end
      end
      amg_pkg::OP_READ_EDGE: begin
        if (from_ok && to_ok) begin
          cmd_o.kind   = amg_pkg::CMD_READ;
          cmd_o.status = 1'b0;
        end
      end
      default: begin
        cmd_o.status = 1'b1;
      end
    endcase
    cmd_o.vertex_count = amg_pkg::COUNT_W'(count_d);
    cmd_o.graph_empty  = (count_d == '0);
  end

  // Hold mode, presence bits and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
      present_q  <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        directed_q <= cfg_wdata_i;
      end
      if (accept) begin
        present_q <= present_d;
        count_q   <= count_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/amg_fifo.sv =====
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module amg_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire amg_pkg::cmd_t wdata_i,
  input  wire logic          pop_i,
  output amg_pkg::cmd_t      rdata_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int unsigned DEPTH = amg_pkg::CMD_QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  amg_pkg::cmd_t entry_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] fill_q;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign rdata_o = entry_q[rptr_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/amg_back.sv =====
// Back end: carries out matrix writes, clears and reads, and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module amg_back #(
  parameter int unsigned MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire amg_pkg::cmd_t                cmd_i,
  input  wire logic                         queue_empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              status_o,
  output logic [amg_pkg::WEIGHT_W-1:0]      weight_read_o,
  output logic [amg_pkg::COUNT_W-1:0]       vertex_count_o,
  output logic                              graph_empty_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned AW = 2 * VW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MIRROR = 4'b0010,
    ST_CLEAR  = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  amg_pkg::cmd_t                 cmd_q;
  logic [VW-1:0]                 idx_q, idx_d;
  logic                          col_phase_q, col_phase_d;
  logic                          slot_free;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_addr;
  logic [amg_pkg::WEIGHT_W-1:0]  ram_wdata, ram_rdata;
  logic                          load;
  amg_pkg::cmd_t                 load_cmd;
  logic [amg_pkg::WEIGHT_W-1:0]  load_weight;
  logic                          out_valid_q;
  logic                          status_q;
  logic [amg_pkg::WEIGHT_W-1:0]  weight_q;
  logic [amg_pkg::COUNT_W-1:0]   count_q;
  logic                          empty_q;

  assign slot_free = !out_valid_q || !out_stall_i;

  amg_ram #(
    .WIDTH (amg_pkg::WEIGHT_W),
    .DEPTH (1 << AW)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequence matrix accesses for the current word
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    col_phase_d = col_phase_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = {cmd_i.from_vertex[VW-1:0], cmd_i.to_vertex[VW-1:0]};
    ram_wdata   = cmd_i.weight;
    load        = 1'b0;
    load_cmd    = cmd_q;
    load_weight = '0;
    case (state_q)
      ST_IDLE: begin
        load_cmd = cmd_i;
        if (!queue_empty_i && slot_free) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            amg_pkg::CMD_WRITE: begin
              ram_we = 1'b1;
              if (cmd_i.mirror) begin
                state_d = ST_MIRROR;
              end else begin
                load = 1'b1;
              end
            end
            amg_pkg::CMD_READ: begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end
            amg_pkg::CMD_CLEAR: begin
              idx_d       = '0;
              col_phase_d = 1'b0;
              state_d     = ST_CLEAR;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_MIRROR: begin
        // Write the transposed entry
        ram_we    = 1'b1;
        ram_addr  = {cmd_q.to_vertex[VW-1:0], cmd_q.from_vertex[VW-1:0]};
        ram_wdata = cmd_q.weight;
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        // Walk the row, then the column, writing zero
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = col_phase_q ? {idx_q, cmd_q.from_vertex[VW-1:0]}
                                : {cmd_q.from_vertex[VW-1:0], idx_q};
        if (idx_q == VW'(MAX_VERTICES - 1)) begin
          if (!col_phase_q) begin
            idx_d       = '0;
            col_phase_d = 1'b1;
          end else if (slot_free) begin
            load    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      ST_READ: begin
        load_weight = ram_rdata;
        if (slot_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the popped word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (load) begin
      status_q <= load_cmd.status;
      weight_q <= load_weight;
      count_q  <= load_cmd.vertex_count;
      empty_q  <= load_cmd.graph_empty;
    end
  end

  // Advance state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      col_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      col_phase_q <= col_phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign weight_read_o  = weight_q;
  assign vertex_count_o = count_q;
  assign graph_empty_o  = empty_q;

endmodule
`default_nettype wire

// ===== src/adjacency_matrix_graph_store.sv =====
// Top level of the weighted adjacency matrix graph store.
// Requests come in on the in channel (in_valid_i / in_stall_o) as one word of
// operation, vertices and weight; every request gives exactly one result word
// on the out channel (out_valid_o / out_stall_i) in request order.
// The user must write directed_mode through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. The front end checks
// vertices and keeps the presence bits and vertex count, then queues a command;
// the back end does the matrix work on a single-port RAM with one weight per
// vertex pair (each side rounded up to a power of two), so one word is worked at
// a time. Vertex removal, failures and directed edge writes finish in the idle
// state; mirrored edge writes then write the transposed entry, edge reads wait
// for the registered RAM word, and add vertex zeroes the new vertex's row and
// column before any edge can touch it. The front keeps accepting into the
// two-entry queue while a result waits, and reset empties the graph and
// selects undirected mode at once; the matrix needs no clearing pass, since a
// row and column are cleared on vertex add. A stalled result holds, and the
// back end waits with it.
`timescale 1ns / 1ps
`default_nettype none
module adjacency_matrix_graph_store #(
  parameter int unsigned MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [amg_pkg::OP_W-1:0]             operation_i,
  input  wire logic [amg_pkg::VTX_W-1:0]            from_vertex_i,
  input  wire logic [amg_pkg::VTX_W-1:0]            to_vertex_i,
  input  wire logic signed [amg_pkg::WEIGHT_W-1:0]  edge_weight_in_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic                                      status_o,
  output logic signed [amg_pkg::WEIGHT_W-1:0]       weight_read_o,
  output logic [amg_pkg::COUNT_W-1:0]               vertex_count_o,
  output logic                                      graph_empty_o
);

  amg_pkg::cmd_t                push_cmd, head_cmd;
  logic                         push, pop, queue_full, queue_empty;
  logic [amg_pkg::WEIGHT_W-1:0] weight_read;

  amg_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .from_vertex_i    (from_vertex_i),
    .to_vertex_i      (to_vertex_i),
    .edge_weight_in_i (edge_weight_in_i),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  amg_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  amg_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .queue_empty_i  (queue_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .weight_read_o  (weight_read),
    .vertex_count_o (vertex_count_o),
    .graph_empty_o  (graph_empty_o)
  );

  assign weight_read_o = weight_read;

endmodule
`default_nettype wire
